[rtl/ewra_pkg.sv]
`default_nettype none
package ewra_pkg;

   localparam int SUM_W = 48;
   localparam int CNT_W = 24;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_ACCUM = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [1:0]       CSR_WMAX_ADDR = 2'd0;
   localparam logic [30:0]      WMAX_RESET    = 31'd2684355;
   localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
   // floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for any x below 2^32
   localparam logic [31:0]      DIV10_RECIP   = 32'hCCCC_CCCD;
   localparam logic [3:0]       WIN_STEPS     = 4'd10;

   typedef struct packed {
      logic             sat;
      logic [CNT_W-1:0] cnt;
      logic [SUM_W-1:0] sum;
   } acc_entry_type;

   typedef struct packed {
      logic latch;
      logic latch_rd;
      logic load_wr;
      logic setup;
      logic win_issue;
      logic rd_issue;
      logic out_load;
      logic clear_step;
   } ewra_cmd_type;

   typedef struct packed {
      logic bx_ok;
      logic clear_last;
      logic cfg_wr;
   } ewra_stat_type;

   // floor(b * k / 10) for b < 10, k <= 10
   function automatic logic [3:0] tenth_floor(input logic [3:0] b, input logic [3:0] k);
      logic [7:0] p;
      logic [3:0] q;
      p = 8'(b) * 8'(k);
      q = 4'd0;
      for (int i = 1; i <= 9; i++) begin
         if (p >= 8'(10 * i)) begin
            q = 4'(i);
         end
      end
      return q;
   endfunction

endpackage
`default_nettype wire

[rtl/ewra_dpath.sv]
`default_nettype none
module ewra_dpath #(
   parameter int MAX_BIEXCITONS = 64,
   parameter int NUM_WINDOWS    = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ewra_pkg::ewra_cmd_type   cmd,
   output      ewra_pkg::ewra_stat_type  stat,
   input  wire logic                     req_channel,
   input  wire logic [5:0]               req_biexciton_index,
   input  wire logic [3:0]               req_window_index,
   input  wire logic [31:0]              req_energy,
   input  wire logic [31:0]              req_weight,
   output      logic [47:0]              rsp_rate_sum,
   output      logic [23:0]              rsp_hit_count,
   output      logic                     rsp_saturated,
   output      logic                     rsp_strobe,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [1:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output      logic [31:0]              prdata,
   output      logic                     pready
);
   import ewra_pkg::*;

   localparam int EAW    = (MAX_BIEXCITONS > 1) ? $clog2(MAX_BIEXCITONS) : 1;
   localparam int ADEPTH = 2 * MAX_BIEXCITONS * NUM_WINDOWS;
   localparam int AAW    = $clog2(ADEPTH);

   // configuration and window-width constants
   logic [30:0] wmax_ff;
   logic [62:0] prod_ff;
   logic [27:0] a_ff;
   logic [3:0]  b_w;
   logic        cfg_wr;

   // latched request
   logic [EAW-1:0]    bx_ff;
   logic              bx_ok_ff;
   logic              win_ok_ff;
   logic [31:0]       energy_ff;
   logic [31:0]       weight_ff;
   logic [AAW-1:0]    slot_ff;
   logic              bx_ok_w;
   logic              win_ok_w;
   logic [31:0]       rd_slot_w;
   logic [31:0]       acc_slot_w;

   // energy store
   logic [31:0]       emem [MAX_BIEXCITONS];
   logic [31:0]       e_q_ff;

   // window sweep
   logic [32:0]       dist_ff;
   logic [30:0]       ak_ff;
   logic [3:0]        k_ff;
   logic [30:0]       width_w;
   logic              hit_ff;
   logic              wr_pend_ff;
   logic [AAW-1:0]    wr_slot_ff;
   logic signed [32:0] diff_w;
   logic [32:0]       dist_w;

   // accumulator store
   acc_entry_type     amem [ADEPTH];
   acc_entry_type     rd_q_ff;
   acc_entry_type     upd_w;
   acc_entry_type     wr_data_w;
   logic [AAW-1:0]    wr_addr_w;
   logic              wr_en_w;
   logic [AAW-1:0]    clr_ff;
   logic [48:0]       sum_w;

   logic              strobe_ff;
   logic [47:0]       out_sum_ff;
   logic [23:0]       out_cnt_ff;
   logic              out_sat_ff;

   // ---------------- configuration port
   assign cfg_wr = psel & penable & pwrite & (paddr == CSR_WMAX_ADDR);
   assign prdata = {1'b0, wmax_ff};
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wmax_ff <= WMAX_RESET;
      end else if (cfg_wr) begin
         wmax_ff <= pwdata[30:0];
      end
   end

   // wmax = 10*a + b; width for k tenths = a*k + floor(b*k/10)
   always_ff @(posedge clock) begin
      prod_ff <= 63'(wmax_ff) * 63'(DIV10_RECIP);
      a_ff    <= prod_ff[62:35];
   end

   assign b_w = wmax_ff[3:0] - 4'({a_ff[3:0], 3'b000} + {3'b000, a_ff[3:0], 1'b0});

   // ---------------- request latch
   assign bx_ok_w    = 32'(req_biexciton_index) < 32'(MAX_BIEXCITONS);
   assign win_ok_w   = 32'(req_window_index) < 32'(NUM_WINDOWS);
   assign rd_slot_w  = (32'(req_channel) * 32'(NUM_WINDOWS) + 32'(req_window_index))
                       * 32'(MAX_BIEXCITONS) + 32'(req_biexciton_index);
   assign acc_slot_w = 32'(req_channel) * 32'(NUM_WINDOWS * MAX_BIEXCITONS)
                       + 32'(req_biexciton_index);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         bx_ff     <= EAW'(req_biexciton_index);
         bx_ok_ff  <= bx_ok_w;
         win_ok_ff <= win_ok_w;
         energy_ff <= req_energy;
         weight_ff <= req_weight;
      end
   end

   // ---------------- energy store, read every cycle at the request index
   always_ff @(posedge clock) begin
      if (cmd.load_wr && bx_ok_ff) begin
         emem[bx_ff] <= energy_ff;
      end
      e_q_ff <= emem[EAW'(req_biexciton_index)];
   end

   // ---------------- window sweep
   assign diff_w  = $signed({energy_ff[31], energy_ff}) - $signed({e_q_ff[31], e_q_ff});
   assign dist_w  = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
   assign width_w = ak_ff + 31'(tenth_floor(b_w, k_ff));

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         slot_ff <= cmd.latch_rd ? AAW'(rd_slot_w) : AAW'(acc_slot_w);
      end else if (cmd.win_issue) begin
         slot_ff <= slot_ff + AAW'(MAX_BIEXCITONS);
      end
      if (cmd.setup) begin
         dist_ff <= dist_w;
         ak_ff   <= 31'({a_ff, 3'b000}) + 31'({a_ff, 1'b0});
         k_ff    <= WIN_STEPS;
      end else if (cmd.win_issue) begin
         ak_ff <= ak_ff - 31'(a_ff);
         k_ff  <= k_ff - 4'd1;
      end
      if (cmd.win_issue) begin
         hit_ff     <= dist_ff <= {2'b00, width_w};
         wr_slot_ff <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pend_ff <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.win_issue;
      end
   end

   // ---------------- accumulator store
   assign sum_w = {1'b0, rd_q_ff.sum} + 49'(weight_ff);

   always_comb begin
      upd_w = rd_q_ff;
      if (sum_w[48]) begin
         upd_w.sum = SUM_MAX;
         upd_w.sat = 1'b1;
      end else begin
         upd_w.sum = sum_w[47:0];
      end
      if (rd_q_ff.cnt == CNT_MAX) begin
         upd_w.sat = 1'b1;
      end else begin
         upd_w.cnt = rd_q_ff.cnt + 24'd1;
      end
   end

   always_comb begin
      if (cmd.clear_step) begin
         wr_en_w   = 1'b1;
         wr_addr_w = clr_ff;
         wr_data_w = '0;
      end else begin
         wr_en_w   = wr_pend_ff & hit_ff;
         wr_addr_w = wr_slot_ff;
         wr_data_w = upd_w;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_w) begin
         amem[wr_addr_w] <= wr_data_w;
      end
      if (cmd.win_issue || cmd.rd_issue) begin
         rd_q_ff <= amem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + AAW'(1);
      end
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.out_load;
      end
      if (cmd.out_load) begin
         if (bx_ok_ff && win_ok_ff) begin
            out_sum_ff <= rd_q_ff.sum;
            out_cnt_ff <= rd_q_ff.cnt;
            out_sat_ff <= rd_q_ff.sat;
         end else begin
            out_sum_ff <= '0;
            out_cnt_ff <= '0;
            out_sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_rate_sum  = out_sum_ff;
   assign rsp_hit_count = out_cnt_ff;
   assign rsp_saturated = out_sat_ff;

   assign stat.bx_ok      = bx_ok_ff;
   assign stat.clear_last = (clr_ff == AAW'(ADEPTH - 1));
   assign stat.cfg_wr     = cfg_wr;

endmodule
`default_nettype wire

[rtl/ewra_ctrl.sv]
`default_nettype none
module ewra_ctrl #(
   parameter int NUM_WINDOWS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              req_action,
   output      logic                    busy,
   output      ewra_pkg::ewra_cmd_type  cmd,
   input  wire ewra_pkg::ewra_stat_type stat
);
   import ewra_pkg::*;

   localparam int CW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_LOAD     = 3'd2;
   localparam logic [2:0] S_SETUP    = 3'd3;
   localparam logic [2:0] S_WIN      = 3'd4;
   localparam logic [2:0] S_RD_ISSUE = 3'd5;
   localparam logic [2:0] S_RD_WAIT  = 3'd6;

   logic [2:0]    state_ff;
   logic [2:0]    state_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [1:0]    settle_ff;
   logic [1:0]    settle_in;
   logic          accept;

   // window widths trail a register write through the prod_ff and a_ff registers
   assign busy   = (state_ff != S_IDLE) || (settle_ff != 2'd0);
   assign accept = start & ~busy;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.latch    = 1'b1;
               cmd.latch_rd = (req_action == ACT_READ);
               unique case (req_action)
                  ACT_LOAD:  state_in = S_LOAD;
                  ACT_ACCUM: state_in = S_SETUP;
                  ACT_READ:  state_in = S_RD_ISSUE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_SETUP: begin
            if (stat.bx_ok) begin
               cmd.setup = 1'b1;
               cnt_in    = '0;
               state_in  = S_WIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WIN: begin
            cmd.win_issue = 1'b1;
            if (cnt_ff == CW'(NUM_WINDOWS - 1)) begin
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            cmd.out_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (stat.cfg_wr) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         cnt_ff    <= '0;
         settle_ff <= 2'd2;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         settle_ff <= settle_in;
      end
   end

endmodule
`default_nettype wire

[rtl/energy_window_rate_accumulator.sv]
`default_nettype none
// Channel   Ports                              Transfer
// --------  ---------------------------------  ---------------------------------------
// request   start, busy, req_*                 edge with start high and busy low
// result    rsp_strobe, rsp_*                  one cycle with rsp_strobe high, no stall
// config    psel/penable/pwrite/paddr/pwdata   access phase, pready always high
//
// Load latches, then writes the energy store. Read issues the RAM read,
// then loads and strobes the result. Accumulate sets up the distance, then
// takes one window per cycle through the accumulator RAM. Reset clears all
// 2*MAX_BIEXCITONS*NUM_WINDOWS entries (1280 by default) with busy high. A
// width write holds busy while widths settle. Results cannot be stalled.
module energy_window_rate_accumulator #(
   parameter int MAX_BIEXCITONS = 64,
   parameter int NUM_WINDOWS    = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_channel,
   input  wire logic [5:0]  req_biexciton_index,
   input  wire logic [3:0]  req_window_index,
   input  wire logic [31:0] req_energy,
   input  wire logic [31:0] req_weight,
   output      logic        rsp_strobe,
   output      logic [47:0] rsp_rate_sum,
   output      logic [23:0] rsp_hit_count,
   output      logic        rsp_saturated,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [1:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   import ewra_pkg::*;

   ewra_cmd_type  cmd;
   ewra_stat_type stat;

   ewra_ctrl #(
      .NUM_WINDOWS (NUM_WINDOWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .cmd        (cmd),
      .stat       (stat)
   );

   ewra_dpath #(
      .MAX_BIEXCITONS (MAX_BIEXCITONS),
      .NUM_WINDOWS    (NUM_WINDOWS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_channel         (req_channel),
      .req_biexciton_index (req_biexciton_index),
      .req_window_index    (req_window_index),
      .req_energy          (req_energy),
      .req_weight          (req_weight),
      .rsp_rate_sum        (rsp_rate_sum),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_saturated       (rsp_saturated),
      .rsp_strobe          (rsp_strobe),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

endmodule
`default_nettype wire

[test/energy_window_rate_accumulator_tb.sv]
`default_nettype none
module energy_window_rate_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ewra_pkg::*;

   localparam int          NUM_BX        = 64;
   localparam int          NUM_WIN       = 10;
   localparam logic [1:0]  ACT_NOP       = 2'd3;
   localparam int          CYCLE_LIMIT   = 3_000_000;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          DRAIN_LIMIT   = 2000;
   localparam int          SAT_ITEMS     = 24;
   localparam int          PHASE_ITEMS   = 120;
   localparam int          MAX_REPORTS   = 10;
   localparam logic [31:0] WEIGHT_FULL   = 32'hFFFF_FFFF;
   localparam logic [31:0] WMAX_FULL     = 32'h7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic        req_channel = 1'b0;
   logic [5:0]  req_biexciton_index = '0;
   logic [3:0]  req_window_index = '0;
   logic [31:0] req_energy = '0;
   logic [31:0] req_weight = '0;
   logic        rsp_strobe;
   logic [47:0] rsp_rate_sum;
   logic [23:0] rsp_hit_count;
   logic        rsp_saturated;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   energy_window_rate_accumulator dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_channel         (req_channel),
      .req_biexciton_index (req_biexciton_index),
      .req_window_index    (req_window_index),
      .req_energy          (req_energy),
      .req_weight          (req_weight),
      .rsp_strobe          (rsp_strobe),
      .rsp_rate_sum        (rsp_rate_sum),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_saturated       (rsp_saturated),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // shadow copy of the block state
   logic [30:0]   width_max_m;
   logic [31:0]   bx_energy_m [NUM_BX];
   bit            bx_loaded [NUM_BX];
   int            loaded_list [$];
   acc_entry_type acc_m [2][NUM_WIN][NUM_BX];
   acc_entry_type pending_reads [$];

   int mismatches    = 0;
   int results_seen  = 0;
   int items_sent    = 0;
   int window_hits   = 0;
   int sat_reads     = 0;
   int width_configs = 0;
   bit idle_bursts   = 1'b1;

   initial forever #5 clock = ~clock;

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   function automatic void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
      end
   endfunction

   function automatic logic [31:0] window_width(int w);
      return 32'((64'(width_max_m) * 64'(WIN_STEPS - w)) / 64'(WIN_STEPS));
   endfunction

   function automatic void model_reset();
      width_max_m = WMAX_RESET;
      loaded_list.delete();
      for (int b = 0; b < NUM_BX; b++) begin
         bx_energy_m[b] = '0;
         bx_loaded[b]   = 1'b0;
         for (int c = 0; c < 2; c++) begin
            for (int w = 0; w < NUM_WIN; w++) begin
               acc_m[c][w][b] = '0;
            end
         end
      end
   endfunction

   function automatic void credit_window(logic ch, int w, logic [5:0] bx, logic [31:0] weight);
      acc_entry_type e;
      logic [48:0]   s;
      e = acc_m[ch][w][bx];
      s = 49'(e.sum) + 49'(weight);
      if (s > 49'(SUM_MAX)) begin
         e.sum = SUM_MAX;
         e.sat = 1'b1;
      end else begin
         e.sum = s[47:0];
      end
      if (e.cnt == CNT_MAX) begin
         e.sat = 1'b1;
      end else begin
         e.cnt = e.cnt + 1'b1;
      end
      acc_m[ch][w][bx] = e;
   endfunction

   function automatic void predict_item(logic [1:0] action, logic ch, logic [5:0] bx,
                                        logic [3:0] win, logic [31:0] energy,
                                        logic [31:0] weight);
      longint        gap;
      acc_entry_type r;
      case (action)
         ACT_LOAD: begin
            bx_energy_m[bx] = energy;
            if (!bx_loaded[bx]) begin
               loaded_list.push_back(int'(bx));
            end
            bx_loaded[bx] = 1'b1;
         end
         ACT_ACCUM: begin
            gap = longint'($signed(energy)) - longint'($signed(bx_energy_m[bx]));
            if (gap < 0) begin
               gap = -gap;
            end
            for (int w = 0; w < NUM_WIN; w++) begin
               if (gap <= longint'(window_width(w))) begin
                  credit_window(ch, w, bx, weight);
                  window_hits++;
               end
            end
         end
         ACT_READ: begin
            r = '0;
            if (win < NUM_WIN) begin
               r = acc_m[ch][win][bx];
            end
            pending_reads.push_back(r);
         end
         default: begin
         end
      endcase
   endfunction

   // start is left high on return so back-to-back transfers need no gap
   task automatic send_item(logic [1:0] action, logic ch, logic [5:0] bx, logic [3:0] win,
                            logic [31:0] energy, logic [31:0] weight);
      req_action          <= action;
      req_channel         <= ch;
      req_biexciton_index <= bx;
      req_window_index    <= win;
      req_energy          <= energy;
      req_weight          <= weight;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      predict_item(action, ch, bx, win, energy, weight);
      items_sent++;
   endtask

   // junk on the request fields while start is low
   task automatic pause(int n);
      start               <= 1'b0;
      req_action          <= 2'($urandom);
      req_channel         <= 1'($urandom);
      req_biexciton_index <= 6'($urandom);
      req_window_index    <= 4'($urandom);
      req_energy          <= $urandom;
      req_weight          <= $urandom;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         pause($urandom_range(1, 5));
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      for (int n = 0; pending_reads.size() != 0 && n < DRAIN_LIMIT; n++) begin
         @(posedge clock);
      end
      while (busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] value);
      settle();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CSR_WMAX_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      width_max_m = value[30:0];
      width_configs++;
      // read back in the following transfer
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {1'b0, width_max_m}) begin
         flag("width readback", 64'({1'b0, width_max_m}), 64'(prdata));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      acc_entry_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_reads.size() == 0) begin
            flag("result with nothing pending", '0, 64'(rsp_rate_sum));
         end else begin
            want = pending_reads.pop_front();
            if (want.sat) begin
               sat_reads++;
            end
            if (rsp_rate_sum !== want.sum) begin
               flag("rate_sum", 64'(want.sum), 64'(rsp_rate_sum));
            end
            if (rsp_hit_count !== want.cnt) begin
               flag("hit_count", 64'(want.cnt), 64'(rsp_hit_count));
            end
            if (rsp_saturated !== want.sat) begin
               flag("saturated", 64'(want.sat), 64'(rsp_saturated));
            end
         end
      end
   end

   task automatic test_cleared_after_reset();
      send_item(ACT_READ, 1'b0, 6'd0, 4'd0, $urandom, $urandom);
      maybe_pause();
      send_item(ACT_READ, 1'b1, 6'd63, 4'd9, $urandom, $urandom);
      maybe_pause();
   endtask

   task automatic test_window_edges();
      logic [31:0] e0;
      e0 = 32'h0123_4567;
      send_item(ACT_LOAD, 1'b0, 6'd5, 4'd0, e0, $urandom);
      send_item(ACT_ACCUM, 1'b0, 6'd5, 4'd0, e0 + window_width(9), 32'd3);
      maybe_pause();
      send_item(ACT_ACCUM, 1'b0, 6'd5, 4'd0, e0 + window_width(9) + 1, 32'd5);
      send_item(ACT_ACCUM, 1'b0, 6'd5, 4'd0, e0 - window_width(0), 32'd7);
      maybe_pause();
      send_item(ACT_ACCUM, 1'b0, 6'd5, 4'd0, e0 - window_width(0) - 1, 32'd11);
      send_item(ACT_ACCUM, 1'b0, 6'd5, 4'd0, e0 + window_width(4), 32'd13);
      send_item(ACT_READ, 1'b0, 6'd5, 4'd0, '0, '0);
      send_item(ACT_READ, 1'b0, 6'd5, 4'd4, '0, '0);
      maybe_pause();
      send_item(ACT_READ, 1'b0, 6'd5, 4'd5, '0, '0);
      send_item(ACT_READ, 1'b0, 6'd5, 4'd9, '0, '0);
      send_item(ACT_READ, 1'b1, 6'd5, 4'd0, '0, '0);
   endtask

   task automatic test_window_out_of_range();
      send_item(ACT_READ, 1'b0, 6'd5, 4'd10, $urandom, $urandom);
      maybe_pause();
      send_item(ACT_READ, 1'b0, 6'd5, 4'd15, $urandom, $urandom);
   endtask

   task automatic test_ignored_action();
      send_item(ACT_NOP, 1'b0, 6'd5, 4'd15, 32'h0123_4567, WEIGHT_FULL);
      send_item(ACT_READ, 1'b0, 6'd5, 4'd0, '0, '0);
      maybe_pause();
   endtask

   task automatic test_energy_extremes();
      csr_write(WMAX_FULL);
      send_item(ACT_LOAD, 1'b1, 6'd63, 4'd0, 32'h8000_0000, '0);
      // distance 2^32-1: outside every window
      send_item(ACT_ACCUM, 1'b1, 6'd63, 4'd0, 32'h7FFF_FFFF, WEIGHT_FULL);
      // distance 2^31-1: exactly the widest window
      send_item(ACT_ACCUM, 1'b1, 6'd63, 4'd0, 32'hFFFF_FFFF, WEIGHT_FULL);
      send_item(ACT_READ, 1'b1, 6'd63, 4'd0, '0, '0);
      send_item(ACT_READ, 1'b1, 6'd63, 4'd1, '0, '0);
   endtask

   task automatic test_width_register();
      // bit 31 of the write data has no storage behind it
      csr_write(32'h8000_0000);
      send_item(ACT_LOAD, 1'b0, 6'd10, 4'd0, '0, '0);
      send_item(ACT_ACCUM, 1'b0, 6'd10, 4'd0, 32'd0, 32'd9);
      maybe_pause();
      send_item(ACT_ACCUM, 1'b0, 6'd10, 4'd0, 32'd1, 32'd9);
      send_item(ACT_ACCUM, 1'b0, 6'd10, 4'd0, 32'hFFFF_FFFF, 32'd9);
      send_item(ACT_READ, 1'b0, 6'd10, 4'd9, '0, '0);
      send_item(ACT_READ, 1'b0, 6'd10, 4'd0, '0, '0);
      csr_write(32'(WMAX_RESET));
   endtask

   task automatic test_repeated_credit();
      send_item(ACT_LOAD, 1'b0, 6'd62, 4'd0, 32'h0F00_0000, '0);
      for (int i = 0; i < SAT_ITEMS; i++) begin
         send_item(ACT_ACCUM, 1'b1, 6'd62, 4'($urandom), 32'h0F00_0000, WEIGHT_FULL);
      end
      for (int w = 0; w < NUM_WIN; w++) begin
         send_item(ACT_READ, 1'b1, 6'd62, 4'(w), '0, '0);
      end
      send_item(ACT_READ, 1'b0, 6'd62, 4'd0, '0, '0);
   endtask

   task automatic random_item();
      int          pick;
      int          wsel;
      logic [5:0]  bx;
      logic [3:0]  win;
      logic [31:0] energy;
      logic [31:0] weight;
      longint      span;
      longint      offset;
      pick = $urandom_range(0, 99);
      if (pick < 15 || loaded_list.size() == 0) begin
         send_item(ACT_LOAD, 1'($urandom), 6'($urandom), 4'($urandom), $urandom, $urandom);
      end else if (pick < 60) begin
         bx   = 6'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
         wsel = $urandom_range(0, 9);
         if (wsel == 0) begin
            energy = $urandom;
         end else if (wsel < 3) begin
            // right on a window boundary, give or take one
            offset = longint'(window_width($urandom_range(0, NUM_WIN - 1)));
            offset = offset + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) begin
               offset = -offset;
            end
            energy = 32'(longint'($signed(bx_energy_m[bx])) + offset);
         end else begin
            span   = longint'(window_width(0)) * 5 / 4 + 2;
            offset = longint'({$urandom, $urandom} >> 1) % (2 * span + 1) - span;
            energy = 32'(longint'($signed(bx_energy_m[bx])) + offset);
         end
         wsel = $urandom_range(0, 9);
         if (wsel < 4) begin
            weight = $urandom_range(0, 255);
         end else if (wsel == 4) begin
            weight = WEIGHT_FULL;
         end else begin
            weight = $urandom;
         end
         send_item(ACT_ACCUM, 1'($urandom), bx, 4'($urandom), energy, weight);
      end else if (pick < 95) begin
         if (loaded_list.size() != 0 && $urandom_range(0, 9) < 7) begin
            bx = 6'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
         end else begin
            bx = 6'($urandom);
         end
         if ($urandom_range(0, 99) < 85) begin
            win = 4'($urandom_range(0, NUM_WIN - 1));
         end else begin
            win = 4'($urandom_range(NUM_WIN, 15));
         end
         send_item(ACT_READ, 1'($urandom), bx, win, $urandom, $urandom);
      end else begin
         send_item(ACT_NOP, 1'($urandom), 6'($urandom), 4'($urandom), $urandom, $urandom);
      end
   endtask

   task automatic test_random_traffic();
      logic [31:0] widths [4];
      widths[0] = 32'(WMAX_RESET);
      widths[1] = 32'd1000;
      widths[2] = $urandom;
      widths[3] = WMAX_FULL;
      for (int p = 0; p < 4; p++) begin
         csr_write(widths[p]);
         // no idling in the last phase
         idle_bursts = (p != 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_item();
            maybe_pause();
         end
      end
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      test_cleared_after_reset();
      test_window_edges();
      test_window_out_of_range();
      test_ignored_action();
      test_energy_extremes();
      test_width_register();
      test_repeated_credit();
      test_random_traffic();

      settle();
      if (pending_reads.size() != 0) begin
         flag("reads never answered", '0, 64'(pending_reads.size()));
      end
      $display("ran %0d transfers, checked %0d read results (%0d saturated), %0d window credits",
               items_sent, results_seen, sat_reads, window_hits);
      $display("%0d width settings including zero and full scale; %0d mismatches",
               width_configs, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
